>>> rtl/core/sqp_pkg.sv
// Package for the sorted priority queue.
// Holds command and status codes, default sizes and the cell control type.
// No dependencies.
package sqp_pkg;

  // Default sizes for the top-level parameters.
  localparam int CAPACITY_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Status codes returned with each result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain at once.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue: a chain of slot cells kept in ascending priority order.
// Depends on sqp_pkg and sqp_cell.
//
// Every command (insert, pop, peek, clear) is taken when start is high and
// busy is low, and its result appears on the result ports, marked by done,
// in the following cycle for exactly one cycle. All slots compare against
// the new priority at once and shift in the same edge, so a new command can
// be issued in every cycle; busy is high only during reset and in the first
// cycle after it. The receiver cannot stall, so results must be captured
// when done is high. Equal priorities leave in arrival order.
module sorted_priority_queue #(
  parameter int CAPACITY     = sqp_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = sqp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [15:0] entry_priority,
  input  logic [31:0]        payload,
  output logic               done,
  output logic [31:0]        head_payload,
  output logic signed [15:0] head_priority,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     accept;
  logic                     full;
  logic                     empty;
  sqp_pkg::cell_ctrl_t      ctrl;
  logic [PAYLOAD_BITS-1:0]  new_pay;
  logic [63:0]              pay_wide;
  logic [63:0]              head_wide;
  logic [31:0]              count_wide;

  logic                     occ [CAPACITY];
  logic                     gt  [CAPACITY];
  logic signed [15:0]       pri_q [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  pay_q [CAPACITY];

  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);

  // Fit the input word to the stored payload width.
  assign pay_wide = {32'b0, payload};
  assign new_pay  = pay_wide[PAYLOAD_BITS-1:0];

  // Broadcast operation for the chain.
  assign ctrl.insert = accept && (command == sqp_pkg::CMD_INSERT) && !full;
  assign ctrl.pop    = accept && (command == sqp_pkg::CMD_POP) && !empty;

  // Row of slot cells, each linked to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_gt;
    logic signed [15:0]      left_pri;
    logic [PAYLOAD_BITS-1:0] left_pay;
    logic signed [15:0]      right_pri;
    logic [PAYLOAD_BITS-1:0] right_pay;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_pri = entry_priority;
      assign left_pay = new_pay;
    end else begin : g_mid
      assign left_gt  = gt[i-1];
      assign left_pri = pri_q[i-1];
      assign left_pay = pay_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_pri = pri_q[i];
      assign right_pay = pay_q[i];
    end else begin : g_inner
      assign right_pri = pri_q[i+1];
      assign right_pay = pay_q[i+1];
    end

    sqp_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ[i]),
      .new_pri  (entry_priority),
      .new_pay  (new_pay),
      .left_gt  (left_gt),
      .left_pri (left_pri),
      .left_pay (left_pay),
      .right_pri(right_pri),
      .right_pay(right_pay),
      .gt       (gt[i]),
      .pri      (pri_q[i]),
      .pay      (pay_q[i])
    );
  end

  // Entry count after the command.
  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end else if (accept && (command == sqp_pkg::CMD_CLEAR)) begin
      count_next = '0;
    end
  end

  assign head_wide  = 64'(pay_q[0]);
  assign count_wide = 32'(count_next);

  // Control state and the registered result of each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      done  <= accept;
    end
    head_payload  <= '0;
    head_priority <= '0;
    status        <= sqp_pkg::ST_OK;
    entry_count   <= count_wide[4:0];
    case (command)
      sqp_pkg::CMD_INSERT: begin
        if (full) begin
          status <= sqp_pkg::ST_FULL;
        end
      end
      sqp_pkg::CMD_POP, sqp_pkg::CMD_PEEK: begin
        if (empty) begin
          status <= sqp_pkg::ST_EMPTY;
        end else begin
          head_payload  <= head_wide[31:0];
          head_priority <= pri_q[0];
        end
      end
      default: begin
      end
    endcase
  end

  // The count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Every accepted item yields a result in the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item gave no result");

  // An insert with room grows the queue by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the queue");

  // A full status is only reported while every slot is held.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == sqp_pkg::ST_FULL) |-> full)
    else $error("full status with free slots");

  // Insert and pop never act in the same cycle.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.insert && ctrl.pop))
    else $error("insert and pop together");

endmodule

>>> rtl/core/sqp_cell.sv
// One slot of the sorted chain: a priority and a payload register.
// Depends on sqp_pkg for the cell control type.
module sqp_cell #(
  parameter int PAYLOAD_BITS = sqp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  sqp_pkg::cell_ctrl_t     ctrl,
  input  logic                    occupied,
  input  logic signed [15:0]      new_pri,
  input  logic [PAYLOAD_BITS-1:0] new_pay,
  input  logic                    left_gt,
  input  logic signed [15:0]      left_pri,
  input  logic [PAYLOAD_BITS-1:0] left_pay,
  input  logic signed [15:0]      right_pri,
  input  logic [PAYLOAD_BITS-1:0] right_pay,
  output logic                    gt,
  output logic signed [15:0]      pri,
  output logic [PAYLOAD_BITS-1:0] pay
);

  logic signed [15:0]      pri_next;
  logic [PAYLOAD_BITS-1:0] pay_next;

  // An empty slot counts as greater, so a new item lands in the first slot that is free or holds a greater priority.
  // A strict compare keeps items of equal priority in arrival order.
  assign gt = !occupied || (pri > new_pri);

  // Shift right behind the insertion point, load at it, or shift left on pop.
  always_comb begin
    pri_next = pri;
    pay_next = pay;
    if (ctrl.insert) begin
      if (left_gt) begin
        pri_next = left_pri;
        pay_next = left_pay;
      end else if (gt) begin
        pri_next = new_pri;
        pay_next = new_pay;
      end
    end else if (ctrl.pop) begin
      pri_next = right_pri;
      pay_next = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    pri <= pri_next;
    pay <= pay_next;
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the sorted priority queue.
// A directed table of commands is followed by random fill, drain and mixed phases,
// and results are checked against typed rows or a software copy of the queue. Needs sqp_pkg.
module tb;

  localparam int DEPTH        = sqp_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ROWS         = 15;

  typedef struct {
    logic [31:0]        pay;
    logic signed [15:0] pri;
    logic [1:0]         st;
    logic [4:0]         cnt;
  } head_result_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] pri;
    logic [31:0]        pay;
    bit                 typed;
    head_result_t       res;
  } stim_row_t;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               start          = 1'b0;
  logic [1:0]         command        = sqp_pkg::CMD_PEEK;
  logic signed [15:0] entry_priority = '0;
  logic [31:0]        payload        = '0;
  logic               busy;
  logic               done;
  logic [31:0]        head_payload;
  logic signed [15:0] head_priority;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  // Tag that travels with the item on the bus: a typed-in expectation, if any.
  bit           row_typed  = 1'b0;
  head_result_t row_result = '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd0};
  head_result_t no_head    = '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd0};

  // Software copy of the queue contents.
  logic signed [15:0] model_pri [DEPTH];
  logic [31:0]        model_pay [DEPTH];
  int                 model_count = 0;

  head_result_t pending_heads[$];
  int           fail_count = 0;
  int           cycles     = 0;
  stim_row_t    directed_rows[ROWS];

  sorted_priority_queue dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .entry_priority (entry_priority),
    .payload        (payload),
    .done           (done),
    .head_payload   (head_payload),
    .head_priority  (head_priority),
    .status         (status),
    .entry_count    (entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the software queue and work out its result.
  task automatic predict_head(input logic [1:0] cmd, input logic signed [15:0] pri,
                              input logic [31:0] pay, output head_result_t res);
    int pos;
    int i;
    res = '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd0};
    case (cmd)
      sqp_pkg::CMD_INSERT: begin
        if (model_count >= DEPTH) begin
          res.st = sqp_pkg::ST_FULL;
        end else begin
          // Ties go behind every entry of equal priority.
          pos = 0;
          while (pos < model_count && model_pri[pos] <= pri) pos++;
          for (i = model_count; i > pos; i--) begin
            model_pri[i] = model_pri[i-1];
            model_pay[i] = model_pay[i-1];
          end
          model_pri[pos] = pri;
          model_pay[pos] = pay;
          model_count++;
        end
      end
      sqp_pkg::CMD_POP, sqp_pkg::CMD_PEEK: begin
        if (model_count == 0) begin
          res.st = sqp_pkg::ST_EMPTY;
        end else begin
          res.pay = model_pay[0];
          res.pri = model_pri[0];
          if (cmd == sqp_pkg::CMD_POP) begin
            for (i = 1; i < model_count; i++) begin
              model_pri[i-1] = model_pri[i];
              model_pay[i-1] = model_pay[i];
            end
            model_count--;
          end
        end
      end
      sqp_pkg::CMD_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    res.cnt = model_count[4:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Results are sampled at the rising edge; accepted items are predicted there too.
  always @(posedge clk) begin
    head_result_t got;
    head_result_t want;
    head_result_t pred;
    if (!rst) begin
      if (done === 1'b1) begin
        got = '{head_payload, head_priority, status, entry_count};
        if (pending_heads.size() == 0) begin
          $display("%0t: result with none expected: payload %h priority %h status %h count %h",
                   $time, got.pay, got.pri, got.st, got.cnt);
          fail_count++;
        end else begin
          want = pending_heads.pop_front();
          check_field("head_payload", want.pay, got.pay);
          check_field("head_priority", want.pri, got.pri);
          check_field("status", want.st, got.st);
          check_field("entry_count", want.cnt, got.cnt);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predict_head(command, entry_priority, payload, pred);
        if (row_typed) begin
          pending_heads.push_back(row_result);
        end else begin
          pending_heads.push_back(pred);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_priority_queue: mismatch");
      $finish;
    end
  end

  // Present one item at the falling edge and hold it until it is taken.
  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] pri,
                           input logic [31:0] pay, input bit typed,
                           input head_result_t res);
    @(negedge clk);
    start          <= 1'b1;
    command        <= cmd;
    entry_priority <= pri;
    payload        <= pay;
    row_typed      <= typed;
    row_result     <= res;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and put noise on the fields.
  task automatic sender_gap();
    @(negedge clk);
    start          <= 1'b0;
    command        <= 2'($urandom);
    entry_priority <= 16'($urandom);
    payload        <= $urandom;
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk);
  endtask

  initial begin
    int                 sent;
    int                 phase;
    int                 mode;
    int                 len;
    int                 k;
    int                 r;
    logic [1:0]         cmd;
    logic signed [15:0] pri;

    // Directed table: empty queue, extreme priorities, ties, clear.
    directed_rows[0]  = '{sqp_pkg::CMD_POP, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_EMPTY, 5'd0}};
    directed_rows[1]  = '{sqp_pkg::CMD_PEEK, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_EMPTY, 5'd0}};
    directed_rows[2]  = '{sqp_pkg::CMD_INSERT, 16'sh7fff, 32'hffff_ffff, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd1}};
    directed_rows[3]  = '{sqp_pkg::CMD_INSERT, 16'sh8000, 32'd0, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd2}};
    directed_rows[4]  = '{sqp_pkg::CMD_INSERT, 16'sd0, 32'ha5a5_a5a5, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd3}};
    directed_rows[5]  = '{sqp_pkg::CMD_INSERT, 16'sd0, 32'h5a5a_5a5a, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd4}};
    directed_rows[6]  = '{sqp_pkg::CMD_PEEK, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sh8000, sqp_pkg::ST_OK, 5'd4}};
    directed_rows[7]  = '{sqp_pkg::CMD_POP, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sh8000, sqp_pkg::ST_OK, 5'd3}};
    directed_rows[8]  = '{sqp_pkg::CMD_POP, 16'sd0, 32'd0, 1'b1,
                          '{32'ha5a5_a5a5, 16'sd0, sqp_pkg::ST_OK, 5'd2}};
    directed_rows[9]  = '{sqp_pkg::CMD_POP, 16'sd0, 32'd0, 1'b1,
                          '{32'h5a5a_5a5a, 16'sd0, sqp_pkg::ST_OK, 5'd1}};
    directed_rows[10] = '{sqp_pkg::CMD_CLEAR, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd0}};
    directed_rows[11] = '{sqp_pkg::CMD_POP, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_EMPTY, 5'd0}};
    directed_rows[12] = '{sqp_pkg::CMD_INSERT, 16'shffff, 32'h0000_0001, 1'b0, no_head};
    directed_rows[13] = '{sqp_pkg::CMD_PEEK, 16'sh1234, 32'hdead_beef, 1'b0, no_head};
    directed_rows[14] = '{sqp_pkg::CMD_CLEAR, 16'sd0, 32'd0, 1'b1,
                          '{32'd0, 16'sd0, sqp_pkg::ST_OK, 5'd0}};

    // Hold reset, then release it at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].pri, directed_rows[i].pay,
                directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases: fill past full, drain past empty, and mixed traffic.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(8, 40);
      if (phase % 8 == 0) drain_results();
      for (k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        // No gaps at all in one long stretch.
        if (!(sent >= 600 && sent < 900) && $urandom_range(0, 99) < 50) sender_gap();
        r = $urandom_range(0, 99);
        case (mode)
          0: cmd = (r < 85) ? sqp_pkg::CMD_INSERT :
                   (r < 95) ? sqp_pkg::CMD_PEEK : sqp_pkg::CMD_POP;
          1: cmd = (r < 80) ? sqp_pkg::CMD_POP :
                   (r < 95) ? sqp_pkg::CMD_PEEK : sqp_pkg::CMD_INSERT;
          default: cmd = (r < 40) ? sqp_pkg::CMD_INSERT : (r < 70) ? sqp_pkg::CMD_POP :
                         (r < 96) ? sqp_pkg::CMD_PEEK : sqp_pkg::CMD_CLEAR;
        endcase
        // Narrow priority ranges make ties common.
        case ($urandom_range(0, 3))
          0: pri = 16'($urandom_range(0, 6) - 3);
          1: begin
            case ($urandom_range(0, 3))
              0: pri = 16'sh8000;
              1: pri = 16'sh7fff;
              2: pri = 16'shffff;
              default: pri = 16'sd0;
            endcase
          end
          default: pri = 16'($urandom);
        endcase
        send_item(cmd, pri, $urandom, 1'b0, no_head);
        sent++;
      end
      phase++;
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
